@@ hdl/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types, sizes and codes of the sparse scatter-add core.
// ----------------------------------------------------------------------------
package csa_pkg;

    // pattern sizes
    localparam int NUM_DOF     = 4096;
    localparam int NUM_NONZERO = 65536;
    localparam int COL_AW      = $clog2(NUM_DOF + 1);
    localparam int DOF_AW      = $clog2(NUM_DOF);
    localparam int NZ_AW       = $clog2(NUM_NONZERO);
    localparam int CLR_N       = (NUM_NONZERO > NUM_DOF) ? NUM_NONZERO : NUM_DOF;
    localparam int CLR_AW      = $clog2(CLR_N);

    // field widths
    localparam int ACTION_W = 3;
    localparam int POS_W    = 17;
    localparam int WORD_W   = 17;
    localparam int DOF_W    = 13;
    localparam int TERM_W   = 64;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int PTR_W    = 17;
    localparam int ROW_W    = 12;

    localparam int S_BITS    = ACTION_W + POS_W + WORD_W + 2 * DOF_W + TERM_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS    = DATA_W + STATUS_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_COL  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ROW  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD_STIFF = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ADD_FORCE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RD_VALUE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RD_FORCE  = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SKIP    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                col_we;
        logic                row_we;
        logic                col_rd;
        logic                col_hi;
        logic                row_rd;
        logic                t_load;
        logic                end_load;
        logic                t_inc;
        logic                val_rd;
        logic                val_at_t;
        logic                frc_rd;
        logic                frc_at_col;
        logic                use_frc;
        logic                add_start;
        logic                val_wr;
        logic                frc_wr;
        logic                clr_wr;
        logic                st_pre;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                data_load;
        logic                out_load;
    } csa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                pre_ok;
        logic                walk_end;
        logic                row_eq;
        logic                row_gt;
        logic                add_done;
        logic                clr_last;
        logic                out_free;
    } csa_stat_t;

endpackage

@@ hdl/csr_sparse_scatter_add_core.sv @@
// Loads, skipped and out-of-range operations are decoded and answered; reads fetch the stored word;
// force adds read the force entry and run the double adder, cut short for NaN or infinite operands.
// Stiffness add: read column bounds, walk row indices, run the adder; a missing row ends the walk.
// Clear stores: one store entry per cycle, over 65536 entries.
// Throughput: one transaction in flight; the next is taken the cycle after its result is loaded.
// Reset: a clearing pass over 65536 entries zeroes both stores with s_tready low.
// ----------------------------------------------------------------------------
// csr_sparse_scatter_add_core
// Compressed-sparse-column scatter-add with double-precision accumulation.
// ----------------------------------------------------------------------------
module csr_sparse_scatter_add_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // action, position, load_word, column_dof, row_dof, term (from bit 0 up)
    input  logic [csa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // read_data, status (from bit 0 up)
    output logic [csa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import csa_pkg::*;

    csa_cmd_t  cmd;
    csa_stat_t stat;

    csa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    csa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ hdl/csa_fadd.sv @@
// ----------------------------------------------------------------------------
// csa_fadd
// Multi-cycle IEEE 754 double adder, round to nearest even.
// ----------------------------------------------------------------------------
module csa_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] sum
);
    import csa_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_SWAP  = 7'b0000010,
        F_ALIGN = 7'b0000100,
        F_ADD   = 7'b0001000,
        F_NORM  = 7'b0010000,
        F_ROUND = 7'b0100000,
        F_DONE  = 7'b1000000
    } fadd_state_t;

    localparam logic [10:0] EXP_MAX = 11'h7FF;
    localparam logic [63:0] NAN_DEF = 64'hFFF8_0000_0000_0000;

    fadd_state_t state_reg, state_next;

    logic [63:0] a_reg, b_reg, res_reg, res_next;
    logic        sx_reg, sx_next, sub_reg, sub_next, sign_reg, sign_next;
    logic [11:0] ex_reg, ex_next, ey_reg, ey_next, e_reg, e_next;
    logic [52:0] mx_reg, mx_next, my_reg, my_next;
    logic [55:0] al_reg, al_next;
    logic [56:0] s_reg, s_next;

    // operand classification
    logic        a_big, a_nan, b_nan, a_inf, b_inf;
    logic [63:0] x_op, y_op;
    // alignment
    logic [11:0] d_diff;
    logic [55:0] full, shifted, mask;
    // rounding
    logic        up;
    logic [53:0] m_rnd;
    logic [52:0] m_fin;
    logic [11:0] e_fin;

    always_comb begin
        a_big = a_reg[62:0] >= b_reg[62:0];
        x_op  = a_big ? a_reg : b_reg;
        y_op  = a_big ? b_reg : a_reg;
        a_nan = (a_reg[62:52] == EXP_MAX) && (a_reg[51:0] != '0);
        b_nan = (b_reg[62:52] == EXP_MAX) && (b_reg[51:0] != '0);
        a_inf = (a_reg[62:52] == EXP_MAX) && (a_reg[51:0] == '0);
        b_inf = (b_reg[62:52] == EXP_MAX) && (b_reg[51:0] == '0);

        d_diff  = ex_reg - ey_reg;
        full    = {my_reg, 3'b000};
        shifted = full >> d_diff[5:0];
        mask    = (56'd1 << d_diff[5:0]) - 56'd1;

        up    = s_reg[2] & (s_reg[3] | s_reg[1] | s_reg[0]);
        m_rnd = {1'b0, s_reg[55:3]} + 54'(up);
        m_fin = m_rnd[53] ? m_rnd[53:1] : m_rnd[52:0];
        e_fin = m_rnd[53] ? e_reg + 12'd1 : e_reg;
    end

    // sequencing of the add steps
    always_comb begin
        state_next = state_reg;
        sx_next    = sx_reg;
        sub_next   = sub_reg;
        sign_next  = sign_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        e_next     = e_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        al_next    = al_reg;
        s_next     = s_reg;
        res_next   = res_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (start) state_next = F_SWAP;
            end
            F_SWAP: begin
                sx_next  = x_op[63];
                sub_next = x_op[63] ^ y_op[63];
                ex_next  = (x_op[62:52] == '0) ? 12'd1 : {1'b0, x_op[62:52]};
                ey_next  = (y_op[62:52] == '0) ? 12'd1 : {1'b0, y_op[62:52]};
                mx_next  = {x_op[62:52] != '0, x_op[51:0]};
                my_next  = {y_op[62:52] != '0, y_op[51:0]};
                if (a_nan) begin
                    res_next   = a_reg | (64'd1 << 51);
                    state_next = F_DONE;
                end else if (b_nan) begin
                    res_next   = b_reg | (64'd1 << 51);
                    state_next = F_DONE;
                end else if (a_inf && b_inf && (a_reg[63] != b_reg[63])) begin
                    res_next   = NAN_DEF;
                    state_next = F_DONE;
                end else if (a_inf) begin
                    res_next   = a_reg;
                    state_next = F_DONE;
                end else if (b_inf) begin
                    res_next   = b_reg;
                    state_next = F_DONE;
                end else begin
                    state_next = F_ALIGN;
                end
            end
            F_ALIGN: begin
                if (d_diff >= 12'd56) begin
                    al_next = {55'd0, |my_reg};
                end else begin
                    al_next = {shifted[55:1], shifted[0] | (|(full & mask))};
                end
                state_next = F_ADD;
            end
            F_ADD: begin
                if (sub_reg) begin
                    s_next = {1'b0, mx_reg, 3'b000} - {1'b0, al_reg};
                end else begin
                    s_next = {1'b0, mx_reg, 3'b000} + {1'b0, al_reg};
                end
                // exact cancellation gives plus zero
                sign_next  = (sub_reg && (s_next == '0)) ? 1'b0 : sx_reg;
                e_next     = ex_reg;
                state_next = F_NORM;
            end
            F_NORM: begin
                if (s_reg == '0) begin
                    state_next = F_ROUND;
                end else if (s_reg[56]) begin
                    s_next     = {1'b0, s_reg[56:2], s_reg[1] | s_reg[0]};
                    e_next     = e_reg + 12'd1;
                    state_next = F_ROUND;
                end else if ((s_reg[55:48] == '0) && (e_reg > 12'd8)) begin
                    s_next = {s_reg[48:0], 8'd0};
                    e_next = e_reg - 12'd8;
                end else if (!s_reg[55] && (e_reg > 12'd1)) begin
                    s_next = {s_reg[55:0], 1'b0};
                    e_next = e_reg - 12'd1;
                end else begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND: begin
                if (e_fin >= 12'd2047) begin
                    res_next = {sign_reg, EXP_MAX, 52'd0};
                end else begin
                    res_next = {sign_reg, m_fin[52] ? e_fin[10:0] : 11'd0, m_fin[51:0]};
                end
                state_next = F_DONE;
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // operand and working registers
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        sx_reg   <= sx_next;
        sub_reg  <= sub_next;
        sign_reg <= sign_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        e_reg    <= e_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        al_reg   <= al_next;
        s_reg    <= s_next;
        res_reg  <= res_next;
    end

    assign done = (state_reg == F_DONE);
    assign sum  = res_reg;

endmodule

@@ hdl/csa_dp.sv @@
// ----------------------------------------------------------------------------
// csa_dp
// Datapath: input capture, pattern and value stores, adder, result register.
// ----------------------------------------------------------------------------
module csa_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [csa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csa_pkg::M_TDATA_W-1:0] m_tdata,
    input  csa_pkg::csa_cmd_t             cmd,
    output csa_pkg::csa_stat_t            stat
);
    import csa_pkg::*;

    // captured transaction fields
    logic [ACTION_W-1:0] action_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [DOF_W-1:0]    col_reg;
    logic [DOF_W-1:0]    row_reg;
    logic [TERM_W-1:0]   term_reg;

    // stores
    logic [PTR_W-1:0]  col_mem [NUM_DOF + 1];
    logic [ROW_W-1:0]  row_mem [NUM_NONZERO];
    logic [DATA_W-1:0] val_mem [NUM_NONZERO];
    logic [DATA_W-1:0] frc_mem [NUM_DOF];

    logic [PTR_W-1:0]  col_q;
    logic [ROW_W-1:0]  row_q;
    logic [DATA_W-1:0] val_q, frc_q;

    logic [PTR_W-1:0]    t_reg, end_reg;
    logic [CLR_AW-1:0]   clr_reg;
    logic [STATUS_W-1:0] status_reg, pre_status;
    logic [DATA_W-1:0]   data_reg;
    logic                m_tvalid_reg;
    logic [M_BITS-1:0]   m_tdata_reg;

    logic [DOF_AW-1:0] col_idx;
    logic [COL_AW-1:0] col_rd_addr;
    logic              val_we, frc_we;
    logic [NZ_AW-1:0]  val_wa, val_ra;
    logic [DOF_AW-1:0] frc_wa, frc_ra;
    logic [DATA_W-1:0] val_wd, frc_wd, add_a, add_sum;
    logic              add_done, col_neg, row_neg, col_big, row_big;

    // capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_tdata[ACTION_W-1:0];
            pos_reg    <= s_tdata[ACTION_W +: POS_W];
            word_reg   <= s_tdata[ACTION_W + POS_W +: WORD_W];
            col_reg    <= s_tdata[ACTION_W + POS_W + WORD_W +: DOF_W];
            row_reg    <= s_tdata[ACTION_W + POS_W + WORD_W + DOF_W +: DOF_W];
            term_reg   <= s_tdata[ACTION_W + POS_W + WORD_W + 2 * DOF_W +: TERM_W];
        end
    end

    // range and constraint checks of the captured operation
    always_comb begin
        col_neg = col_reg[DOF_W-1];
        row_neg = row_reg[DOF_W-1];
        col_big = 32'(col_reg[DOF_W-2:0]) >= NUM_DOF;
        row_big = 32'(row_reg[DOF_W-2:0]) >= NUM_DOF;
        unique case (action_reg)
            ACT_LOAD_COL:  pre_status = (32'(pos_reg) > NUM_DOF) ? STAT_RANGE : STAT_DONE;
            ACT_LOAD_ROW:  pre_status = (32'(pos_reg) >= NUM_NONZERO) ? STAT_RANGE : STAT_DONE;
            ACT_CLEAR:     pre_status = STAT_DONE;
            ACT_ADD_STIFF: pre_status = (col_neg || row_neg) ? STAT_SKIP :
                                        (col_big || row_big) ? STAT_RANGE : STAT_DONE;
            ACT_ADD_FORCE: pre_status = col_neg ? STAT_SKIP :
                                        col_big ? STAT_RANGE : STAT_DONE;
            ACT_RD_VALUE:  pre_status = (32'(pos_reg) >= NUM_NONZERO) ? STAT_RANGE : STAT_DONE;
            ACT_RD_FORCE:  pre_status = (32'(pos_reg) >= NUM_DOF) ? STAT_RANGE : STAT_DONE;
            default:       pre_status = STAT_RANGE;
        endcase
    end

    // addresses and write data
    always_comb begin
        col_idx     = col_reg[DOF_AW-1:0];
        col_rd_addr = cmd.col_hi ? COL_AW'(col_idx) + COL_AW'(1) : COL_AW'(col_idx);
        val_we      = (cmd.clr_wr && (32'(clr_reg) < NUM_NONZERO)) || cmd.val_wr;
        val_wa      = cmd.clr_wr ? clr_reg[NZ_AW-1:0] : t_reg[NZ_AW-1:0];
        val_wd      = cmd.clr_wr ? '0 : add_sum;
        val_ra      = cmd.val_at_t ? t_reg[NZ_AW-1:0] : pos_reg[NZ_AW-1:0];
        frc_we      = (cmd.clr_wr && (32'(clr_reg) < NUM_DOF)) || cmd.frc_wr;
        frc_wa      = cmd.clr_wr ? clr_reg[DOF_AW-1:0] : col_idx;
        frc_wd      = cmd.clr_wr ? '0 : add_sum;
        frc_ra      = cmd.frc_at_col ? col_idx : pos_reg[DOF_AW-1:0];
        add_a       = cmd.use_frc ? frc_q : val_q;
    end

    // column start store
    always_ff @(posedge aclk) begin
        if (cmd.col_we) col_mem[pos_reg[COL_AW-1:0]] <= word_reg;
        if (cmd.col_rd) col_q <= col_mem[col_rd_addr];
    end

    // row index store
    always_ff @(posedge aclk) begin
        if (cmd.row_we) row_mem[pos_reg[NZ_AW-1:0]] <= word_reg[ROW_W-1:0];
        if (cmd.row_rd) row_q <= row_mem[t_reg[NZ_AW-1:0]];
    end

    // value store
    always_ff @(posedge aclk) begin
        if (val_we) val_mem[val_wa] <= val_wd;
        if (cmd.val_rd) val_q <= val_mem[val_ra];
    end

    // force store
    always_ff @(posedge aclk) begin
        if (frc_we) frc_mem[frc_wa] <= frc_wd;
        if (cmd.frc_rd) frc_q <= frc_mem[frc_ra];
    end

    // column walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.t_load) begin
            t_reg <= col_q;
        end else if (cmd.t_inc) begin
            t_reg <= t_reg + PTR_W'(1);
        end
        if (cmd.end_load) end_reg <= col_q;
    end

    // clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= stat.clr_last ? '0 : clr_reg + CLR_AW'(1);
        end
    end

    // result fields
    always_ff @(posedge aclk) begin
        if (cmd.st_pre) begin
            status_reg <= pre_status;
        end else if (cmd.st_load) begin
            status_reg <= cmd.st_code;
        end
        if (cmd.capture) begin
            data_reg <= '0;
        end else if (cmd.data_load) begin
            data_reg <= add_a;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_tdata_reg <= {status_reg, data_reg};
    end

    csa_fadd u_fadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.add_start),
        .op_a    (add_a),
        .op_b    (term_reg),
        .done    (add_done),
        .sum     (add_sum)
    );

    // status toward the controller
    always_comb begin
        stat.action   = action_reg;
        stat.pre_ok   = (pre_status == STAT_DONE);
        stat.walk_end = (t_reg >= end_reg) || (32'(t_reg) >= NUM_NONZERO);
        stat.row_eq   = (row_q == row_reg[ROW_W-1:0]);
        stat.row_gt   = (row_q > row_reg[ROW_W-1:0]);
        stat.add_done = add_done;
        stat.clr_last = (32'(clr_reg) == CLR_N - 1);
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_tdata_reg);

endmodule

@@ hdl/csa_ctrl.sv @@
// ----------------------------------------------------------------------------
// csa_ctrl
// Controller: sequences loads, clears, column walks and read-modify-writes.
// ----------------------------------------------------------------------------
module csa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output csa_pkg::csa_cmd_t  cmd,
    input  csa_pkg::csa_stat_t stat
);
    import csa_pkg::*;

    typedef enum logic [11:0] {
        S_BOOT     = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_DECODE   = 12'b000000000100,
        S_CLEAR    = 12'b000000001000,
        S_COL_LO   = 12'b000000010000,
        S_COL_HI   = 12'b000000100000,
        S_WALK_CHK = 12'b000001000000,
        S_WALK_CMP = 12'b000010000000,
        S_FETCH    = 12'b000100000000,
        S_ADD      = 12'b001000000000,
        S_RDATA    = 12'b010000000000,
        S_FINISH   = 12'b100000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.use_frc = (stat.action == ACT_ADD_FORCE) || (stat.action == ACT_RD_FORCE);
        unique case (state_reg)
            S_BOOT: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.st_pre = 1'b1;
                state_next = S_FINISH;
                if (stat.pre_ok) begin
                    unique case (stat.action)
                        ACT_LOAD_COL:  cmd.col_we = 1'b1;
                        ACT_LOAD_ROW:  cmd.row_we = 1'b1;
                        ACT_CLEAR:     state_next = S_CLEAR;
                        ACT_ADD_STIFF: begin
                            cmd.col_rd = 1'b1;
                            state_next = S_COL_LO;
                        end
                        ACT_ADD_FORCE: begin
                            cmd.frc_rd     = 1'b1;
                            cmd.frc_at_col = 1'b1;
                            state_next     = S_FETCH;
                        end
                        ACT_RD_VALUE: begin
                            cmd.val_rd = 1'b1;
                            state_next = S_RDATA;
                        end
                        ACT_RD_FORCE: begin
                            cmd.frc_rd = 1'b1;
                            state_next = S_RDATA;
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) state_next = S_FINISH;
            end
            S_COL_LO: begin
                cmd.t_load = 1'b1;
                cmd.col_rd = 1'b1;
                cmd.col_hi = 1'b1;
                state_next = S_COL_HI;
            end
            S_COL_HI: begin
                cmd.end_load = 1'b1;
                state_next   = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (stat.walk_end) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = STAT_MISSING;
                    state_next  = S_FINISH;
                end else begin
                    cmd.row_rd = 1'b1;
                    state_next = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (stat.row_eq) begin
                    cmd.val_rd   = 1'b1;
                    cmd.val_at_t = 1'b1;
                    state_next   = S_FETCH;
                end else if (stat.row_gt) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = STAT_MISSING;
                    state_next  = S_FINISH;
                end else begin
                    cmd.t_inc  = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end
            S_FETCH: begin
                cmd.add_start = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD: begin
                if (stat.add_done) begin
                    cmd.val_wr = !cmd.use_frc;
                    cmd.frc_wr = cmd.use_frc;
                    state_next = S_FINISH;
                end
            end
            S_RDATA: begin
                cmd.data_load = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_BOOT;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

@@ hdl/csa_check.sv @@
// ----------------------------------------------------------------------------
// csa_check
// Port-level checks of the scatter-add core, bound to the top level.
// ----------------------------------------------------------------------------
module csa_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [csa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import csa_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // data is zero unless the status is done
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[DATA_W +: STATUS_W] != STAT_DONE) |-> m_tdata[DATA_W-1:0] == '0)
        else $error("nonzero data with error status");

    // one transaction at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    // reset empties the output and blocks input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity right after reset");

endmodule

bind csr_sparse_scatter_add_core csa_check u_csa_check (.*);
